// ----- rtl/core/rhc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the rgb to hsv converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int STEP_BITS  = 2;
	localparam int DIV_STAGES = FRAC_BITS / STEP_BITS;

	localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic hue_zero;
		logic sat_zero;
		logic sat_full;
	} pix_flags_t;

endpackage

// ----- rtl/core/rhc_frac_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_frac_div
// Pipelined restoring divider for a proper fraction rem / dvs (rem < dvs),
// producing FRAC_BITS quotient bits, STEP_BITS bits per register stage.
// ----------------------------------------------------------------------------
module rhc_frac_div #(
	parameter int DW = 8
) (
	input  logic                          clk,
	input  logic [DW-1:0]                 rem,
	input  logic [DW-1:0]                 dvs,
	output logic [rhc_pkg::FRAC_BITS-1:0] quo
);
	import rhc_pkg::*;

	logic [DW-1:0]        rem_s [DIV_STAGES];
	logic [DW-1:0]        dvs_s [DIV_STAGES];
	logic [FRAC_BITS-1:0] quo_s [DIV_STAGES];

	genvar k;
	for (k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DW-1:0]        rem_in;
		logic [DW-1:0]        dvs_in;
		logic [FRAC_BITS-1:0] quo_in;
		logic [DW-1:0]        rem_nx;
		logic [FRAC_BITS-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = rem;
			assign dvs_in = dvs;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		always_comb begin
			logic [DW:0] r2;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int i = 0; i < STEP_BITS; i++) begin
				r2 = {rem_nx, 1'b0};
				if (r2 >= {1'b0, dvs_in}) begin
					r2     = r2 - {1'b0, dvs_in};
					quo_nx = {quo_nx[FRAC_BITS-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[FRAC_BITS-2:0], 1'b0};
				end
				rem_nx = r2[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			dvs_s[k] <= dvs_in;
			quo_s[k] <= quo_nx;
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ----- rtl/core/rgb_to_hsv_convert.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// RGB pixel to hue, saturation, brightness and chroma, fully pipelined.
// ----------------------------------------------------------------------------
// usage:
//   a pixel transaction is taken on a rising edge with start high and busy
//   low; busy is always low, so a pixel may be offered every cycle
//   each result is shown for one cycle with done high, after its pixel has
//   passed every stage; one result per cycle sustained, in pixel order
//   pipeline: one stage for max/min and chroma, one for the hue numerator and
//   divisor, 8 divider stages (2 quotient bits each), one output register
//   hue and saturation come from two parallel restoring dividers that run
//   side by side in the same 8 stages
//   reset clears the valid bits of every stage, so no result is shown until
//   a pixel is taken after reset
//   the receiver cannot stall; results are never held or repeated
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert #(
	parameter int COMPONENT_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [COMPONENT_BITS-1:0]     red,
	input  logic [COMPONENT_BITS-1:0]     green,
	input  logic [COMPONENT_BITS-1:0]     blue,
	output logic                          done,
	output logic [rhc_pkg::FRAC_BITS-1:0] hue,
	output logic [rhc_pkg::FRAC_BITS-1:0] saturation,
	output logic [COMPONENT_BITS-1:0]     brightness,
	output logic [COMPONENT_BITS-1:0]     chroma
);
	import rhc_pkg::*;

	localparam int N  = COMPONENT_BITS;
	localparam int HW = COMPONENT_BITS + 3;

	// stage 1
	logic          vld_s1;
	logic [N-1:0]  r_s1, g_s1, b_s1, v_s1, c_s1;
	sector_t       sec_s1;
	sector_t       sec_c;
	logic [N-1:0]  v_c, lo_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sec_c = SEC_RED;
			v_c   = red;
		end else if (green >= blue) begin
			sec_c = SEC_GREEN;
			v_c   = green;
		end else begin
			sec_c = SEC_BLUE;
			v_c   = blue;
		end
		lo_c = red;
		if (green < lo_c) lo_c = green;
		if (blue < lo_c) lo_c = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		r_s1   <= red;
		g_s1   <= green;
		b_s1   <= blue;
		v_s1   <= v_c;
		c_s1   <= v_c - lo_c;
		sec_s1 <= sec_c;
	end

	// stage 2
	logic          vld_s2;
	logic [N-1:0]  v_s2, c_s2;
	logic [HW-1:0] num_s2, d6_s2;
	pix_flags_t    flg_s2;
	logic [HW-1:0] c2_c, c4_c, c6_c, base_c, x_c, y_c;
	pix_flags_t    flg_c;

	always_comb begin
		c2_c = {2'b00, c_s1, 1'b0};
		c4_c = {1'b0, c_s1, 2'b00};
		c6_c = c4_c + c2_c;
		case (sec_s1)
			SEC_RED: begin
				base_c = (g_s1 < b_s1) ? c6_c : '0;
				x_c    = {3'b000, g_s1};
				y_c    = {3'b000, b_s1};
			end
			SEC_GREEN: begin
				base_c = c2_c;
				x_c    = {3'b000, b_s1};
				y_c    = {3'b000, r_s1};
			end
			default: begin
				base_c = c4_c;
				x_c    = {3'b000, r_s1};
				y_c    = {3'b000, g_s1};
			end
		endcase
		flg_c.hue_zero = (c_s1 == '0);
		flg_c.sat_zero = (v_s1 == '0);
		flg_c.sat_full = (c_s1 == v_s1) && (v_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s2   <= v_s1;
		c_s2   <= c_s1;
		num_s2 <= base_c + x_c - y_c;
		d6_s2  <= c6_c;
		flg_s2 <= flg_c;
	end

	// divider stages
	logic [FRAC_BITS-1:0] hue_quo, sat_quo;

	rhc_frac_div #(.DW(HW)) u_hue_div (
		.clk (clk),
		.rem (num_s2),
		.dvs (d6_s2),
		.quo (hue_quo)
	);

	rhc_frac_div #(.DW(N)) u_sat_div (
		.clk (clk),
		.rem (c_s2),
		.dvs (v_s2),
		.quo (sat_quo)
	);

	logic       vld_sd [DIV_STAGES];
	logic [N-1:0] v_sd [DIV_STAGES];
	logic [N-1:0] c_sd [DIV_STAGES];
	pix_flags_t flg_sd [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				vld_sd[i] <= 1'b0;
			end
		end else begin
			vld_sd[0] <= vld_s2;
			for (int i = 1; i < DIV_STAGES; i++) begin
				vld_sd[i] <= vld_sd[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		v_sd[0]   <= v_s2;
		c_sd[0]   <= c_s2;
		flg_sd[0] <= flg_s2;
		for (int i = 1; i < DIV_STAGES; i++) begin
			v_sd[i]   <= v_sd[i-1];
			c_sd[i]   <= c_sd[i-1];
			flg_sd[i] <= flg_sd[i-1];
		end
	end

	// output register
	pix_flags_t flg_o;
	assign flg_o = flg_sd[DIV_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sd[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		hue        <= flg_o.hue_zero ? '0 : hue_quo;
		saturation <= flg_o.sat_zero ? '0 : (flg_o.sat_full ? FRAC_MAX : sat_quo);
		brightness <= v_sd[DIV_STAGES-1];
		chroma     <= c_sd[DIV_STAGES-1];
	end

	assign busy = 1'b0;

endmodule
